// File: hw/rtl/imu_pkg.sv
// Shared types, codes and sizing constants for the Ising Metropolis update block.
// No dependencies; every other file except imu_ram references this package by scoped name.
package imu_pkg;

    // Lattice geometry (SIDE must be a power of two, at most 2**IDX_W)
    localparam int SIDE       = 64;
    localparam int SIDE_W     = $clog2(SIDE);
    localparam int SITES      = SIDE * SIDE;

    // Field and register widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 6;
    localparam int RND_W      = 32;
    localparam int MAG_W      = 14;
    localparam int BOND_W     = 15;
    localparam int NUM_THRESH = 5;
    localparam int SEL_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 64;

    // Command queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // Operation codes on the input channel
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLIP  = 2'd2;

    // Reset values of the running sums
    localparam logic [MAG_W-1:0]  MAG_RST  = MAG_W'(SITES);
    localparam logic [BOND_W-1:0] BOND_RST = BOND_W'(2 * SITES);

    typedef logic [SIDE_W-1:0] t_idx;
    typedef logic [SIDE-1:0]   t_row;

    typedef enum logic [1:0] {
        K_WRITE,
        K_READ,
        K_FLIP
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        t_idx             row;
        t_idx             col;
        logic             spin;
        logic [RND_W-1:0] rnd;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_UP,
        ST_RD_MID,
        ST_RD_DN,
        ST_CAP_DN,
        ST_EXEC
    } t_state;

endpackage

// File: hw/rtl/ising_metropolis_update_top.sv
// Ising Metropolis update engine, top level. Each command passes a take step,
// three serial row reads through the single lattice RAM read port, a capture step
// and the decide/write-back step; the back end works on one command at a time.
// Reset (synchronous, active low): lattice reads as all up via 64 row valid bits
// cleared at once, sums 4096 / 8192, thresholds all ones. Uses imu_front/back/ram.
module ising_metropolis_update_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [imu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [imu_pkg::CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [imu_pkg::OP_W-1:0]      i_operation,
    input  logic [imu_pkg::IDX_W-1:0]     i_row_index,
    input  logic [imu_pkg::IDX_W-1:0]     i_column_index,
    input  logic                          i_spin_value,
    input  logic [imu_pkg::RND_W-1:0]     i_random_word,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_site_spin,
    output logic                          o_flipped,
    output logic [imu_pkg::MAG_W-1:0]     o_magnetization,
    output logic [imu_pkg::BOND_W-1:0]    o_bond_total
);

    // Front: decode + two-entry command queue. A beat is taken whenever the
    // queue has room, independent of whether a result waits downstream.
    imu_pkg::t_q_head head;
    logic             pop;

    imu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_spin_value   (i_spin_value),
        .i_random_word  (i_random_word),
        .i_pop          (pop),
        .o_head         (head)
    );

    // Back: row reads (up, center, down), decision, write-back, sums and the
    // result register. It stalls only in its execute step on a full result slot.
    imu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_site_spin     (o_site_spin),
        .o_flipped       (o_flipped),
        .o_magnetization (o_magnetization),
        .o_bond_total    (o_bond_total)
    );

endmodule

// File: hw/rtl/imu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/imu_front.sv
// Front end: accepts input beats, decodes the operation, wraps the site
// index and queues commands for the back end. Depends on imu_pkg.
module imu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [imu_pkg::OP_W-1:0]      i_operation,
    input  logic [imu_pkg::IDX_W-1:0]     i_row_index,
    input  logic [imu_pkg::IDX_W-1:0]     i_column_index,
    input  logic                          i_spin_value,
    input  logic [imu_pkg::RND_W-1:0]     i_random_word,
    input  logic                          i_pop,
    output imu_pkg::t_q_head              o_head
);

    imu_pkg::t_cmd                r_mem [imu_pkg::Q_DEPTH];
    logic [imu_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [imu_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [imu_pkg::Q_CNT_W-1:0]  r_count;
    imu_pkg::t_cmd                cmd_in;
    logic                         push;
    logic                         pop;

    // Unused code 3 behaves as a read
    always_comb begin
        cmd_in.row  = i_row_index[imu_pkg::SIDE_W-1:0];
        cmd_in.col  = i_column_index[imu_pkg::SIDE_W-1:0];
        cmd_in.spin = i_spin_value;
        cmd_in.rnd  = i_random_word;
        case (i_operation)
            imu_pkg::OP_WRITE: cmd_in.kind = imu_pkg::K_WRITE;
            imu_pkg::OP_FLIP:  cmd_in.kind = imu_pkg::K_FLIP;
            default:           cmd_in.kind = imu_pkg::K_READ;
        endcase
    end

    assign o_ready = (r_count != imu_pkg::Q_CNT_W'(imu_pkg::Q_DEPTH));
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + imu_pkg::Q_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + imu_pkg::Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + imu_pkg::Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - imu_pkg::Q_CNT_W'(1);
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

endmodule

// File: hw/rtl/imu_back.sv
// Back end: reads the three lattice rows around a site, decides and applies
// the update, tracks the running sums and holds the result beat.
// Depends on imu_pkg and imu_ram.
module imu_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [imu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [imu_pkg::CFG_W-1:0]     i_cfg_data,
    input  imu_pkg::t_q_head              i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_site_spin,
    output logic                          o_flipped,
    output logic [imu_pkg::MAG_W-1:0]     o_magnetization,
    output logic [imu_pkg::BOND_W-1:0]    o_bond_total
);

    imu_pkg::t_state              r_state;
    imu_pkg::t_state              n_state;
    imu_pkg::t_cmd                r_cmd;
    imu_pkg::t_row                r_row_up;
    imu_pkg::t_row                r_row_mid;
    imu_pkg::t_row                r_row_dn;
    logic [imu_pkg::SIDE-1:0]     r_row_vld;
    logic                         r_rd_vld;
    logic [imu_pkg::CFG_W-1:0]    r_thresh [imu_pkg::NUM_THRESH];
    logic [imu_pkg::MAG_W-1:0]    r_mag;
    logic [imu_pkg::BOND_W-1:0]   r_bond;
    logic                         r_out_valid;
    logic                         r_out_spin;
    logic                         r_out_flip;

    imu_pkg::t_idx                row_m;
    imu_pkg::t_idx                row_p;
    imu_pkg::t_idx                col_m;
    imu_pkg::t_idx                col_p;
    imu_pkg::t_idx                ram_raddr;
    imu_pkg::t_row                ram_rdata;
    imu_pkg::t_row                row_rd;
    imu_pkg::t_row                wrow;
    logic                         ram_we;
    logic                         out_free;
    logic                         fire;
    logic                         take_cmd;
    logic                         cap_up;
    logic                         cap_mid;
    logic                         cap_dn;

    logic                         s;
    logic [imu_pkg::SEL_W-1:0]    n_up;
    logic [imu_pkg::SEL_W-1:0]    sel;
    logic [imu_pkg::CFG_W-1:0]    pair;
    logic [imu_pkg::RND_W-1:0]    th;
    logic                         accept;
    logic                         do_flip;
    logic                         new_spin;
    logic [imu_pkg::MAG_W-1:0]    mag_nxt;
    logic [imu_pkg::BOND_W-1:0]   bond_nxt;

    assign row_m = r_cmd.row - imu_pkg::t_idx'(1);
    assign row_p = r_cmd.row + imu_pkg::t_idx'(1);
    assign col_m = r_cmd.col - imu_pkg::t_idx'(1);
    assign col_p = r_cmd.col + imu_pkg::t_idx'(1);

    assign out_free = !r_out_valid || i_ready;

    // Rows never written read as all spins up
    assign row_rd = r_rd_vld ? ram_rdata : '1;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            imu_pkg::ST_IDLE:   if (i_head.valid) n_state = imu_pkg::ST_RD_UP;
            imu_pkg::ST_RD_UP:  n_state = imu_pkg::ST_RD_MID;
            imu_pkg::ST_RD_MID: n_state = imu_pkg::ST_RD_DN;
            imu_pkg::ST_RD_DN:  n_state = imu_pkg::ST_CAP_DN;
            imu_pkg::ST_CAP_DN: n_state = imu_pkg::ST_EXEC;
            imu_pkg::ST_EXEC:   if (out_free) n_state = imu_pkg::ST_IDLE;
            default:            n_state = imu_pkg::ST_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        take_cmd  = 1'b0;
        cap_up    = 1'b0;
        cap_mid   = 1'b0;
        cap_dn    = 1'b0;
        fire      = 1'b0;
        ram_raddr = row_m;
        case (r_state)
            imu_pkg::ST_IDLE:   take_cmd = i_head.valid;
            imu_pkg::ST_RD_UP:  ram_raddr = row_m;
            imu_pkg::ST_RD_MID: begin
                ram_raddr = r_cmd.row;
                cap_up    = 1'b1;
            end
            imu_pkg::ST_RD_DN:  begin
                ram_raddr = row_p;
                cap_mid   = 1'b1;
            end
            imu_pkg::ST_CAP_DN: cap_dn = 1'b1;
            imu_pkg::ST_EXEC:   fire = out_free;
            default:            ;
        endcase
    end

    assign o_pop = take_cmd;

    // ---- update decision ----
    always_comb begin
        s    = r_row_mid[r_cmd.col];
        n_up = imu_pkg::SEL_W'(r_row_up[r_cmd.col]) + imu_pkg::SEL_W'(r_row_dn[r_cmd.col])
             + imu_pkg::SEL_W'(r_row_mid[col_m]) + imu_pkg::SEL_W'(r_row_mid[col_p]);
        // sel = (p + 4) / 2 with p = s * (2*n_up - 4)
        sel  = s ? n_up : (imu_pkg::SEL_W'(4) - n_up);
        pair = r_thresh[sel];
        th   = s ? pair[imu_pkg::RND_W-1:0] : pair[imu_pkg::CFG_W-1:imu_pkg::RND_W];
        accept = (&th) || (r_cmd.rnd < th);
        case (r_cmd.kind)
            imu_pkg::K_FLIP:  do_flip = accept;
            imu_pkg::K_WRITE: do_flip = (s != r_cmd.spin);
            default:          do_flip = 1'b0;
        endcase
        new_spin = s ^ do_flip;
        if (do_flip) begin
            mag_nxt  = s ? (r_mag - imu_pkg::MAG_W'(2)) : (r_mag + imu_pkg::MAG_W'(2));
            // bond -= 2p, 2p = 4*sel - 8
            bond_nxt = r_bond + imu_pkg::BOND_W'(8) - (imu_pkg::BOND_W'(sel) << 2);
        end else begin
            mag_nxt  = r_mag;
            bond_nxt = r_bond;
        end
        wrow = r_row_mid;
        wrow[r_cmd.col] = new_spin;
    end

    assign ram_we = fire && do_flip;

    imu_ram #(
        .WIDTH(imu_pkg::SIDE),
        .DEPTH(imu_pkg::SIDE)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmd.row),
        .i_wdata (wrow),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_row_vld[ram_raddr];
        if (take_cmd) r_cmd <= i_head.cmd;
        if (cap_up)   r_row_up  <= row_rd;
        if (cap_mid)  r_row_mid <= row_rd;
        if (cap_dn)   r_row_dn  <= row_rd;
        if (fire) begin
            r_out_spin <= new_spin;
            r_out_flip <= (r_cmd.kind == imu_pkg::K_FLIP) && do_flip;
        end
    end

    // ---- control and architectural state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imu_pkg::ST_IDLE;
            r_row_vld   <= '0;
            r_mag       <= imu_pkg::MAG_RST;
            r_bond      <= imu_pkg::BOND_RST;
            r_out_valid <= 1'b0;
            for (int k = 0; k < imu_pkg::NUM_THRESH; k++) begin
                r_thresh[k] <= '1;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && (i_cfg_index < imu_pkg::CFG_IDX_W'(imu_pkg::NUM_THRESH))) begin
                r_thresh[i_cfg_index] <= i_cfg_data;
            end
            if (ram_we) begin
                r_row_vld[r_cmd.row] <= 1'b1;
            end
            if (fire) begin
                r_mag       <= mag_nxt;
                r_bond      <= bond_nxt;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_site_spin     = r_out_spin;
    assign o_flipped       = r_out_flip;
    assign o_magnetization = r_mag;
    assign o_bond_total    = r_bond;

endmodule
